[hw/rtl/cfse_pkg.sv]
// Shared types and constants for the CAN signal fragment extract and scale block.
package cfse_pkg;

   // Fixed sizes of the frame and of one fragment descriptor
   localparam logic [3:0] PAYLOAD_BYTES = 4'd8;
   localparam int         DESC_REGS     = 4;
   localparam int         MAX_BIT_COUNT = 127;
   localparam int         USED_W        = 3;
   localparam int         NUM_STAGES    = 5;

   // Q32.32 constants
   localparam logic [63:0] GAIN_RESET = 64'h0000_0001_0000_0000;
   localparam logic [63:0] Q_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Q_MIN      = 64'h8000_0000_0000_0000;
   localparam logic [7:0]  BYTE_MASK  = 8'hFF;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_FRAG_COUNT = 3'd0,
      REG_DESC0      = 3'd1,
      REG_DESC1      = 3'd2,
      REG_DESC2      = 3'd3,
      REG_DESC3      = 3'd4,
      REG_BYTE_SWAP  = 3'd5,
      REG_GAIN       = 3'd6,
      REG_OFFSET     = 3'd7
   } csr_index_type;

   // Fragment descriptor: bit count [15:9], bit offset [8:3], byte offset [2:0]
   typedef struct packed {
      logic [6:0] width_bits;
      logic [5:0] shift_bits;
      logic [2:0] start_byte;
   } desc_type;

   typedef struct packed {
      logic [63:0] payload;
      logic [3:0]  payload_len;
   } req_type;

   typedef struct packed {
      logic [63:0]        raw_value;
      logic signed [63:0] scaled_value;
      logic [2:0]         fragments_used;
      logic               value_clipped;
   } rsp_type;

   // What one lane found
   typedef struct packed {
      logic        used;
      logic [6:0]  width_bits;
      logic [63:0] value;
   } lane_res_type;

   // Merged raw value ahead of scaling
   typedef struct packed {
      logic [63:0]       raw;
      logic [USED_W-1:0] used;
      logic              clipped;
   } merge_res_type;

   // Stage load enables of the scaling pipeline
   typedef struct packed {
      logic s3;
      logic s4;
      logic s5;
   } scale_en_type;

endpackage

[hw/rtl/can_signal_fragment_extract_scale.sv]
// Stages, each registered: lanes, merge, products, product combine, offset add
// into the output register. Throughput: one item per cycle while the result
// side is not stalled; each stage loads whenever the next one frees.
// Stall on the result side backs up stage by stage and then raises req_stall.
// Reset (synchronous): all stages emptied, registers back to count 0, empty
// descriptors, little-endian, gain 1.0 and offset 0.0.
module can_signal_fragment_extract_scale import cfse_pkg::*; #(
   parameter int NUM_FRAGMENTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   // Configuration registers
   logic [2:0]  frag_count_ff;
   logic        byte_swap_ff;
   logic [63:0] gain_ff;
   logic [63:0] offset_ff;
   desc_type    desc_ff [NUM_FRAGMENTS];

   // Pipeline control
   logic [NUM_STAGES-1:0] vld_in, vld_ff;
   logic [NUM_STAGES-1:0] ready;
   scale_en_type          scale_en;

   logic [NUM_FRAGMENTS-1:0]         lane_active;
   lane_res_type [NUM_FRAGMENTS-1:0] lane_res;
   merge_res_type                    merge_res;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frag_count_ff <= 3'd0;
         byte_swap_ff  <= 1'b0;
         gain_ff       <= GAIN_RESET;
         offset_ff     <= 64'd0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            REG_FRAG_COUNT: frag_count_ff <= csr_data[2:0];
            REG_BYTE_SWAP:  byte_swap_ff  <= csr_data[0];
            REG_GAIN:       gain_ff       <= csr_data;
            REG_OFFSET:     offset_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Descriptor registers; lanes without a register index keep an empty one
   for (genvar f = 0; f < NUM_FRAGMENTS; f++) begin : g_desc
      logic desc_we;

      assign desc_we = csr_wr_en && (f < DESC_REGS)
                       && (csr_index >= 3'(REG_DESC0)) && (csr_index <= 3'(REG_DESC3))
                       && (({1'b0, csr_index} - 4'(REG_DESC0)) == 4'(f));

      always_ff @(posedge clock) begin
         if (reset) begin
            desc_ff[f] <= '0;
         end else if (desc_we) begin
            desc_ff[f] <= desc_type'(csr_data[15:0]);
         end
      end

      assign lane_active[f] = (4'(f) < {1'b0, frag_count_ff});
   end

   // Stage ready chain: a stage loads when empty or when the next one moves
   always_comb begin
      ready[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         ready[s] = !vld_ff[s] || ready[s+1];
      end
      vld_in[0] = req_valid;
      for (int s = 1; s < NUM_STAGES; s++) begin
         vld_in[s] = vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            if (ready[s]) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // Extraction lanes
   for (genvar f = 0; f < NUM_FRAGMENTS; f++) begin : g_lane
      cfse_lane u_lane (
         .clock    (clock),
         .load     (ready[0]),
         .active   (lane_active[f]),
         .desc     (desc_ff[f]),
         .req_data (req_data),
         .lane_res (lane_res[f])
      );
   end

   // Merge of lane results
   cfse_merge #(
      .NUM_FRAGMENTS (NUM_FRAGMENTS)
   ) u_merge (
      .clock      (clock),
      .load       (ready[1]),
      .byte_swap  (byte_swap_ff),
      .lane_res   (lane_res),
      .merge_res  (merge_res)
   );

   // Scaling
   assign scale_en.s3 = ready[2];
   assign scale_en.s4 = ready[3];
   assign scale_en.s5 = ready[4];

   cfse_scale u_scale (
      .clock     (clock),
      .en        (scale_en),
      .gain      (gain_ff),
      .offset    (offset_ff),
      .merge_res (merge_res),
      .rsp       (rsp_data)
   );

endmodule

[hw/rtl/cfse_lane.sv]
// One extraction lane: bounds check, gather, shift and mask of a single fragment.
module cfse_lane import cfse_pkg::*; (
   input  logic         clock,
   input  logic         load,
   input  logic         active,
   input  desc_type     desc,
   input  req_type      req_data,
   output lane_res_type lane_res
);

   logic [7:0]   span;
   logic [4:0]   nbytes;
   logic [5:0]   end_byte;
   logic [3:0]   len_c;
   logic         ok;
   logic [63:0]  shifted;
   logic [63:0]  mask;
   lane_res_type lane_res_in;
   lane_res_type lane_res_ff;

   // Byte span of the fragment and bounds check
   assign len_c    = (req_data.payload_len > PAYLOAD_BYTES) ? PAYLOAD_BYTES
                                                            : req_data.payload_len;
   assign span     = {1'b0, desc.width_bits} + {2'b0, desc.shift_bits} + 8'd7;
   assign nbytes   = span[7:3];
   assign end_byte = {3'b0, desc.start_byte} + {1'b0, nbytes};
   assign ok       = active && (desc.width_bits != 7'd0) && (nbytes <= 5'd8)
                     && (end_byte <= {2'b0, len_c});

   // Gather from the byte offset, drop the bit offset, keep the fragment width
   assign shifted = (req_data.payload >> {desc.start_byte, 3'b000}) >> desc.shift_bits;
   assign mask    = desc.width_bits[6] ? {64{1'b1}}
                                       : ((64'd1 << desc.width_bits[5:0]) - 64'd1);

   always_comb begin
      lane_res_in.used       = ok;
      lane_res_in.width_bits = desc.width_bits;
      lane_res_in.value      = ok ? (shifted & mask) : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_res_ff <= lane_res_in;
      end
   end

   assign lane_res = lane_res_ff;

endmodule

[hw/rtl/cfse_merge.sv]
// Merging stage: packs lane results, flags lost bits, optional byte reversal.
module cfse_merge import cfse_pkg::*; #(
   parameter int NUM_FRAGMENTS = 4
) (
   input  logic                             clock,
   input  logic                             load,
   input  logic                             byte_swap,
   input  lane_res_type [NUM_FRAGMENTS-1:0] lane_res,
   output merge_res_type                    merge_res
);

   localparam int TotalW = $clog2(NUM_FRAGMENTS * MAX_BIT_COUNT + 1);
   localparam int CountW = $clog2(NUM_FRAGMENTS + 1);

   logic [TotalW-1:0] total;
   logic [CountW-1:0] count;
   logic [127:0]      wide;
   logic [63:0]       packed_raw;
   logic              lost;
   logic [63:0]       clip_raw;
   logic [63:0]       rev;
   logic [6:0]        nb_sum;
   logic [3:0]        nb;
   logic [3:0]        drop;
   merge_res_type     merge_res_in;
   merge_res_type     merge_res_ff;

   // Each used fragment lands above the earlier ones
   always_comb begin
      total      = '0;
      count      = '0;
      packed_raw = '0;
      lost       = 1'b0;
      wide       = '0;
      for (int f = 0; f < NUM_FRAGMENTS; f++) begin
         if (lane_res[f].used) begin
            wide = {64'd0, lane_res[f].value} << total[5:0];
            if (total >= TotalW'(64)) begin
               lost = lost || (lane_res[f].value != 64'd0);
            end else begin
               lost       = lost || (wide[127:64] != 64'd0);
               packed_raw = packed_raw | wide[63:0];
            end
            total = total + TotalW'(lane_res[f].width_bits);
            count = count + CountW'(1);
         end
      end
   end

   assign clip_raw = lost ? {64{1'b1}} : packed_raw;

   // Byte reversal over ceil(total / 8) bytes, at most eight
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         rev[8*b +: 8] = clip_raw[8*(7-b) +: 8] & BYTE_MASK;
      end
   end

   assign nb_sum = {1'b0, total[5:0]} + 7'd7;
   assign nb     = (total >= TotalW'(64)) ? 4'd8 : nb_sum[6:3];
   assign drop   = 4'd8 - nb;

   always_comb begin
      merge_res_in.used    = USED_W'(count);
      merge_res_in.clipped = lost;
      if (byte_swap && (total > TotalW'(8))) begin
         merge_res_in.raw = rev >> {drop[2:0], 3'b000};
      end else begin
         merge_res_in.raw = clip_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         merge_res_ff <= merge_res_in;
      end
   end

   assign merge_res = merge_res_ff;

endmodule

[hw/rtl/cfse_scale.sv]
// Scaling pipeline: raw times gain plus offset in Q32.32, with saturation.
module cfse_scale import cfse_pkg::*; (
   input  logic          clock,
   input  scale_en_type  en,
   input  logic [63:0]   gain,
   input  logic [63:0]   offset,
   input  merge_res_type merge_res,
   output rsp_type       rsp
);

   // Gain magnitude and biased offset, refreshed from the registers
   logic          neg_in, neg_ff;
   logic [63:0]   mag_in, mag_ff;
   logic [63:0]   bias_in, bias_ff;

   // Stage 3: partial products
   logic [63:0]   pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic [63:0]   pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   merge_res_type m3_ff;

   // Stage 4: low product word and high word test
   logic [33:0]   mid;
   logic [63:0]   lo_in, lo_ff;
   logic          hi_nz_in, hi_nz_ff;
   merge_res_type m4_ff;

   // Stage 5: offset add and saturation
   logic [64:0]   sum_add;
   logic [64:0]   sum_sub;
   rsp_type       rsp_in, rsp_ff;

   assign neg_in  = gain[63];
   assign mag_in  = gain[63] ? (64'd0 - gain) : gain;
   assign bias_in = offset ^ Q_MIN;

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      bias_ff <= bias_in;
   end

   // 32 x 32 partial products
   assign pp_ll_in = merge_res.raw[31:0]  * mag_ff[31:0];
   assign pp_lh_in = merge_res.raw[31:0]  * mag_ff[63:32];
   assign pp_hl_in = merge_res.raw[63:32] * mag_ff[31:0];
   assign pp_hh_in = merge_res.raw[63:32] * mag_ff[63:32];

   always_ff @(posedge clock) begin
      if (en.s3) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
         m3_ff    <= merge_res;
      end
   end

   // Combine into the low word; the high word is only tested for zero
   assign mid      = {2'b00, pp_ll_ff[63:32]} + {2'b00, pp_lh_ff[31:0]}
                     + {2'b00, pp_hl_ff[31:0]};
   assign lo_in    = {mid[31:0], pp_ll_ff[31:0]};
   assign hi_nz_in = (pp_hh_ff != 64'd0) || (pp_lh_ff[63:32] != 32'd0)
                     || (pp_hl_ff[63:32] != 32'd0) || (mid[33:32] != 2'd0);

   always_ff @(posedge clock) begin
      if (en.s4) begin
         lo_ff    <= lo_in;
         hi_nz_ff <= hi_nz_in;
         m4_ff    <= m3_ff;
      end
   end

   // Add or subtract against the biased offset, saturate on carry or borrow
   assign sum_add = {1'b0, bias_ff} + {1'b0, lo_ff};
   assign sum_sub = {1'b0, bias_ff} - {1'b0, lo_ff};

   always_comb begin
      rsp_in.raw_value      = m4_ff.raw;
      rsp_in.fragments_used = m4_ff.used;
      rsp_in.value_clipped  = m4_ff.clipped;
      if (hi_nz_ff) begin
         rsp_in.value_clipped = 1'b1;
         rsp_in.scaled_value  = neg_ff ? Q_MIN : Q_MAX;
      end else if (!neg_ff) begin
         if (sum_add[64]) begin
            rsp_in.value_clipped = 1'b1;
            rsp_in.scaled_value  = Q_MAX;
         end else begin
            rsp_in.scaled_value  = sum_add[63:0] ^ Q_MIN;
         end
      end else begin
         if (sum_sub[64]) begin
            rsp_in.value_clipped = 1'b1;
            rsp_in.scaled_value  = Q_MIN;
         end else begin
            rsp_in.scaled_value  = sum_sub[63:0] ^ Q_MIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

[bench/can_signal_fragment_extract_scale_tb.sv]
// Self-checking testbench for the CAN signal fragment extract and scale block.
`timescale 1ns / 100ps

module can_signal_fragment_extract_scale_tb import cfse_pkg::*; ();

   localparam int HALF_PERIOD  = 5;
   localparam int RANDOM_ITEMS = 1630;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_GAP      = 17;
   localparam int PRINT_CAP    = 40;

   // One full register set as loaded between phases
   typedef struct packed {
      logic [2:0]                   count;
      desc_type [DESC_REGS-1:0]     desc;
      logic                         byte_swap;
      logic [63:0]                  gain;
      logic [63:0]                  offset;
   } signal_cfg_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   // Local copy of the register file
   logic [2:0]  cfg_count;
   desc_type    cfg_desc [DESC_REGS];
   logic        cfg_byte_swap;
   logic [63:0] cfg_gain;
   logic [63:0] cfg_offset;

   rsp_type     expected_signals [$];
   int          mismatch_count  = 0;
   int          results_checked = 0;
   int          frames_sent     = 0;
   int          settings_loaded = 0;
   int          cycle_count     = 0;
   bit          src_idle        = 1'b1;
   bit          sink_idle       = 1'b1;

   can_signal_fragment_extract_scale dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("can_signal_fragment_extract_scale test failed");
         $finish;
      end
   end

   // Expected raw, scaled, used count and clip flag for one frame
   function automatic rsp_type scale_signal(req_type frame);
      rsp_type      res;
      int unsigned  len, cnt, total, used, bo, bi, bc, nbytes, nb, f, i;
      logic [63:0]  raw, part, lost, swapped, mag, bias, lo;
      logic [127:0] product;
      logic         neg, clipped;
      len = frame.payload_len;
      if (len > PAYLOAD_BYTES) len = PAYLOAD_BYTES;
      cnt = cfg_count;
      if (cnt > DESC_REGS) cnt = DESC_REGS;
      raw = '0;
      total = 0;
      used = 0;
      clipped = 1'b0;
      for (f = 0; f < cnt; f++) begin
         bo = cfg_desc[f].start_byte;
         bi = cfg_desc[f].shift_bits;
         bc = cfg_desc[f].width_bits;
         nbytes = (bc + bi + 7) / 8;
         if (bc == 0 || bo + nbytes > len || nbytes > 8) continue;
         part = '0;
         for (i = 0; i < nbytes; i++)
            part |= ((frame.payload >> (8 * (bo + i))) & {56'd0, BYTE_MASK}) << (8 * i);
         part = part >> bi;
         if (bc < 64) part &= (64'd1 << bc) - 64'd1;
         // anything that would land at bit 64 or above is lost
         if (total >= 64) lost = part;
         else if (total == 0) lost = '0;
         else lost = part >> (64 - total);
         if (lost != '0) clipped = 1'b1;
         if (total < 64) raw |= part << total;
         total += bc;
         used++;
      end
      if (clipped) raw = '1;

      // byte reversal over the bytes actually collected
      if (cfg_byte_swap && total > 8) begin
         nb = (total + 7) / 8;
         if (nb > 8) nb = 8;
         swapped = '0;
         for (i = 0; i < nb; i++)
            swapped |= ((raw >> (8 * i)) & {56'd0, BYTE_MASK}) << (8 * (nb - 1 - i));
         raw = swapped;
      end

      // raw * gain + offset, worked on offset-binary so the add is unsigned
      neg = cfg_gain[63];
      mag = neg ? 64'd0 - cfg_gain : cfg_gain;
      product = {64'd0, raw} * {64'd0, mag};
      lo = product[63:0];
      bias = cfg_offset ^ Q_MIN;
      if (product[127:64] != '0) begin
         clipped = 1'b1;
         res.scaled_value = neg ? Q_MIN : Q_MAX;
      end else if (!neg) begin
         if (lo > ~bias) begin
            clipped = 1'b1;
            res.scaled_value = Q_MAX;
         end else begin
            res.scaled_value = (bias + lo) ^ Q_MIN;
         end
      end else if (lo > bias) begin
         clipped = 1'b1;
         res.scaled_value = Q_MIN;
      end else begin
         res.scaled_value = (bias - lo) ^ Q_MIN;
      end
      res.raw_value = raw;
      res.fragments_used = used[2:0];
      res.value_clipped = clipped;
      return res;
   endfunction

   function automatic desc_type make_desc(int bo, int bi, int bc);
      desc_type d;
      d.start_byte = 3'(bo);
      d.shift_bits = 6'(bi);
      d.width_bits = 7'(bc);
      return d;
   endfunction

   function automatic signal_cfg_type reset_cfg();
      signal_cfg_type s;
      s = '0;
      s.gain = GAIN_RESET;
      return s;
   endfunction

   // Mostly fragments that fit the frame, sometimes any descriptor at all
   function automatic desc_type random_desc();
      logic [15:0] bits;
      int          bo, bi, room, bc;
      if ($urandom_range(0, 4) == 0) begin
         bits = 16'($urandom);
         return bits;
      end
      bo = $urandom_range(0, 7);
      room = (8 - bo) * 8;
      bi = $urandom_range(0, 7);
      if ($urandom_range(0, 1) == 1)
         bc = $urandom_range(1, (room - bi < 16) ? room - bi : 16);
      else
         bc = $urandom_range(1, room - bi);
      return make_desc(bo, bi, bc);
   endfunction

   function automatic logic [63:0] random_q32();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 6))
         0: return GAIN_RESET;
         1: return r;
         2: return {{24{r[39]}}, r[39:0]};
         3: return 64'd0 - GAIN_RESET;
         4: return Q_MAX;
         5: return Q_MIN;
         default: return '0;
      endcase
   endfunction

   function automatic signal_cfg_type random_cfg();
      signal_cfg_type s;
      int             d;
      s.count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 4));
      for (d = 0; d < DESC_REGS; d++) s.desc[d] = random_desc();
      s.byte_swap = 1'($urandom_range(0, 1));
      s.gain = random_q32();
      s.offset = ($urandom_range(0, 2) == 0) ? 64'd0 : random_q32();
      return s;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t: %s: got %h, expected %h", $time, field, got, want);
      mismatch_count++;
   endtask

   // Result side: draw a stall length per item, then take the item
   initial begin : rsp_side
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         hold = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Compare every accepted result with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_signals.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_data.raw_value, '0);
         end else begin
            want = expected_signals.pop_front();
            if (rsp_data.raw_value !== want.raw_value)
               report_mismatch("raw_value", rsp_data.raw_value, want.raw_value);
            if (rsp_data.scaled_value !== want.scaled_value)
               report_mismatch("scaled_value", rsp_data.scaled_value, want.scaled_value);
            if (rsp_data.fragments_used !== want.fragments_used)
               report_mismatch("fragments_used", 64'(rsp_data.fragments_used),
                               64'(want.fragments_used));
            if (rsp_data.value_clipped !== want.value_clipped)
               report_mismatch("value_clipped", 64'(rsp_data.value_clipped),
                               64'(want.value_clipped));
            results_checked++;
         end
      end
   end

   // Send one frame; valid stays high across back-to-back items
   task automatic send_frame(logic [63:0] data, logic [3:0] len);
      req_type frame;
      int      gap;
      frame.payload = data;
      frame.payload_len = len;
      gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= frame;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_signals.insert(expected_signals.size(), scale_signal(frame));
      frames_sent++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_signals.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 2) @(posedge clock);
   endtask

   // One register write; the local copy keeps only the register's width
   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         REG_FRAG_COUNT: cfg_count = value[2:0];
         REG_DESC0:      cfg_desc[0] = value[15:0];
         REG_DESC1:      cfg_desc[1] = value[15:0];
         REG_DESC2:      cfg_desc[2] = value[15:0];
         REG_DESC3:      cfg_desc[3] = value[15:0];
         REG_BYTE_SWAP:  cfg_byte_swap = value[0];
         REG_GAIN:       cfg_gain = value;
         REG_OFFSET:     cfg_offset = value;
         default: ;
      endcase
   endtask

   // Writes every register once the block has gone quiet; junk fills unused bits
   task automatic load_settings(signal_cfg_type s, bit junk);
      logic [63:0] pad;
      int          d;
      drain_pipeline();
      pad = junk ? {$urandom, $urandom} : 64'd0;
      write_reg(REG_FRAG_COUNT, {pad[63:3], s.count});
      for (d = 0; d < DESC_REGS; d++)
         write_reg(csr_index_type'(int'(REG_DESC0) + d), {pad[63:16], s.desc[d]});
      write_reg(REG_BYTE_SWAP, {pad[63:1], s.byte_swap});
      write_reg(REG_GAIN, s.gain);
      write_reg(REG_OFFSET, s.offset);
      csr_wr_en <= 1'b0;
      settings_loaded++;
   endtask

   // No fragments in use after reset: raw zero, unit gain, zero offset
   task automatic test_reset_defaults();
      send_frame('1, 4'd8);
      send_frame({$urandom, $urandom}, 4'd0);
   endtask

   // Single fragment at the extremes of width, position and frame length
   task automatic test_single_fragment();
      signal_cfg_type s;
      s = reset_cfg();
      s.count = 3'd1;
      s.desc[0] = make_desc(0, 0, 64);
      load_settings(s, 1'b0);
      send_frame('1, 4'd8);
      send_frame('0, 4'd8);
      send_frame({$urandom, $urandom}, 4'd7);
      send_frame({$urandom, $urandom}, 4'd15);

      // count above the lane total, zero-width and out-of-frame descriptors
      s.count = 3'd7;
      s.desc[0] = make_desc(7, 0, 8);
      s.desc[1] = make_desc(0, 0, 0);
      s.desc[2] = make_desc(3, 63, 1);
      s.desc[3] = make_desc(0, 63, 1);
      load_settings(s, 1'b1);
      send_frame({$urandom, $urandom}, 4'd8);
      send_frame('1, 4'd7);
      send_frame({$urandom, $urandom}, 4'd9);
   endtask

   // Packing of several fragments and loss of bits past 64
   task automatic test_multi_fragment();
      signal_cfg_type s;
      s = reset_cfg();
      s.count = 3'd4;
      s.desc[0] = make_desc(0, 4, 12);
      s.desc[1] = make_desc(2, 0, 16);
      s.desc[2] = make_desc(4, 7, 9);
      s.desc[3] = make_desc(5, 0, 24);
      s.gain = 64'd1;
      load_settings(s, 1'b0);
      send_frame({$urandom, $urandom}, 4'd8);
      send_frame({$urandom, $urandom}, 4'd8);

      // second fragment starts at bit 64; the third needs nine bytes
      s.count = 3'd3;
      s.desc[0] = make_desc(0, 0, 64);
      s.desc[1] = make_desc(0, 0, 1);
      s.desc[2] = make_desc(0, 60, 8);
      s.gain = '0;
      s.offset = 64'd0 - GAIN_RESET;
      load_settings(s, 1'b0);
      send_frame(64'd1, 4'd8);
      send_frame(64'd2, 4'd8);
   endtask

   // Byte reversal: not at 8 bits, two bytes at 9, all eight at 64
   task automatic test_big_endian();
      signal_cfg_type s;
      s = reset_cfg();
      s.byte_swap = 1'b1;
      s.count = 3'd1;
      s.desc[0] = make_desc(0, 0, 8);
      load_settings(s, 1'b0);
      send_frame({$urandom, $urandom}, 4'd8);
      s.count = 3'd2;
      s.desc[1] = make_desc(1, 0, 1);
      load_settings(s, 1'b0);
      send_frame({$urandom, $urandom}, 4'd8);
      s.count = 3'd1;
      s.desc[0] = make_desc(0, 0, 64);
      s.gain = '0;
      load_settings(s, 1'b0);
      send_frame({$urandom, $urandom}, 4'd8);
   endtask

   // Saturation of the multiply-add in both directions
   task automatic test_scaling();
      signal_cfg_type s;
      s = reset_cfg();
      s.count = 3'd1;
      s.desc[0] = make_desc(0, 0, 32);
      s.gain = Q_MIN;
      load_settings(s, 1'b0);
      send_frame(64'd1, 4'd8);
      send_frame(64'd2, 4'd8);
      s.gain = Q_MAX;
      s.offset = Q_MAX;
      load_settings(s, 1'b0);
      send_frame(64'd1, 4'd8);
      send_frame(64'd0, 4'd8);
      s.gain = 64'd0 - GAIN_RESET;
      s.offset = Q_MIN;
      load_settings(s, 1'b0);
      send_frame(64'd1, 4'd8);
   endtask

   // Random settings per phase, random frames, rotating idle patterns
   task automatic test_random_frames();
      signal_cfg_type s;
      logic [3:0]     len;
      int             phase, n, k, sent;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         s = random_cfg();
         load_settings(s, 1'($urandom_range(0, 1)));
         src_idle = ((phase % 4) == 1) || ((phase % 4) == 3);
         sink_idle = ((phase % 4) == 2) || ((phase % 4) == 3);
         n = $urandom_range(30, 90);
         for (k = 0; k < n; k++) begin
            len = ($urandom_range(0, 9) < 7) ? 4'd8 : 4'($urandom_range(0, 15));
            send_frame({$urandom, $urandom}, len);
            sent++;
         end
         phase++;
      end
      src_idle = 1'b1;
      sink_idle = 1'b1;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= REG_FRAG_COUNT;
      csr_data <= '0;
      cfg_count = '0;
      for (int d = 0; d < DESC_REGS; d++) cfg_desc[d] = '0;
      cfg_byte_swap = 1'b0;
      cfg_gain = GAIN_RESET;
      cfg_offset = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_single_fragment();
      test_multi_fragment();
      test_big_endian();
      test_scaling();
      test_random_frames();
      drain_pipeline();

      $display("Sent %0d frames under %0d register settings, %0d results checked.",
               frames_sent, settings_loaded, results_checked);
      $display("Covered bounds, packing overflow, byte reversal and scale saturation.");
      if (mismatch_count == 0)
         $display("can_signal_fragment_extract_scale test passed");
      else
         $display("can_signal_fragment_extract_scale test failed");
      $finish;
   end

endmodule
